FILE: hdl/pll_pkg.sv
// Package for the positional linked list engine: sizes, operation codes, state encodings.
// Used by the top level, the core and the checker; depends on nothing.
package pll_pkg;
	localparam int Capacity  = 64;
	localparam int DataWidth = 32;
	localparam int SlotW     = $clog2(Capacity);
	localparam int LinkW     = SlotW + 1;
	localparam int ModeW     = 4;
	localparam int PosW      = 7;
	localparam int CountW    = 7;
	localparam int NodeW     = DataWidth + 2 * LinkW;
	localparam logic [LinkW-1:0] NilSlot = LinkW'(Capacity);

	typedef enum logic [ModeW-1:0] {
		OP_ADDFIRST = 4'd0,
		OP_ADDLAST  = 4'd1,
		OP_INSERT   = 4'd2,
		OP_SET      = 4'd3,
		OP_GET      = 4'd4,
		OP_REMOVE   = 4'd5,
		OP_REMFIRST = 4'd6,
		OP_REMLAST  = 4'd7,
		OP_NEXT     = 4'd8,
		OP_REWIND   = 4'd9,
		OP_CLEAR    = 4'd10
	} op_t;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_FREE  = 9'b000000010,
		ST_WALK  = 9'b000000100,
		ST_WREAD = 9'b000001000,
		ST_RD    = 9'b000010000,
		ST_RDW   = 9'b000100000,
		ST_UPD   = 9'b001000000,
		ST_UPD2  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;
endpackage

FILE: hdl/pll_if.sv
// Valid/ready channel interface carrying one item of a parametrised payload type.
// Depends on nothing; instanced on both channels of the list engine.
interface pll_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/positional_linked_list_engine.sv
// Top level of the positional linked list engine: channel handshakes around pll_core.
// Depends on pll_pkg, pll_if and pll_core.
//
// One item on in_ch carries mode, position and value; one result item leaves on out_ch with
// ok, data, count and has_next. The block takes one item at a time: in_ch.ready is high only
// while the sequencer is idle and the result register is empty or being taken.
// Rewind, clear, unknown modes, bad positions and next on a null cursor go straight to the
// result; next reads the node at the cursor, and get, set and remove first walk to their node.
// An add scans for the lowest free slot, writes the new node and patches each neighbour by
// a read and a write; an insert inside the list also walks to its successor first.
// Walks start at the nearer end, so a walk is at most Capacity/2 links long. The free-slot
// scan and the walk through the single node memory port keep the block busy, so it takes no
// new item before it is through with the last one: a new item is taken only as the last
// result leaves or once it has left.
// Reset empties the list and clears the cursor; the node memory is not cleared, since a slot
// is always written before it is read.
// When the receiver stalls, the result is held in the output register and no new item is
// taken until it leaves.
module positional_linked_list_engine import pll_pkg::*; (
	input logic clk,
	input logic arst_n,
	pll_if.sink   in_ch,
	pll_if.source out_ch
);
	logic busy, done, ok, has_next;
	logic [DataWidth-1:0] data;
	logic [CountW-1:0] count;
	logic full_q;

	assign in_ch.ready = !busy && (!full_q || out_ch.ready);

	pll_core u_core (
		.clk(clk), .arst_n(arst_n), .start(in_ch.valid && in_ch.ready),
		.mode(in_ch.payload.mode), .position(in_ch.payload.position),
		.value(in_ch.payload.value), .busy(busy), .done(done), .r_ok(ok),
		.r_data(data), .r_count(count), .r_has_next(has_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (done) begin
			full_q <= 1'b1;
		end else if (out_ch.ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_ch.payload.ok       <= ok;
			out_ch.payload.data     <= data;
			out_ch.payload.count    <= count;
			out_ch.payload.has_next <= has_next;
		end
	end

	assign out_ch.valid = full_q;
endmodule

FILE: hdl/pll_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module pll_ram #(parameter int Width = 8, parameter int Depth = 16) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: hdl/pll_core.sv
// Sequencer of the list engine: free-slot search, link walks and link updates.
// Depends on pll_pkg and pll_ram.
module pll_core import pll_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ModeW-1:0]     mode,
	input  logic [PosW-1:0]      position,
	input  logic [DataWidth-1:0] value,
	output logic                 busy,
	output logic                 done,
	output logic                 r_ok,
	output logic [DataWidth-1:0] r_data,
	output logic [CountW-1:0]    r_count,
	output logic                 r_has_next
);
	state_t               state_q;
	logic [ModeW-1:0]     mode_q;
	logic [PosW-1:0]      pos_q;
	logic [DataWidth-1:0] val_q;
	logic [Capacity-1:0]  used_q;
	logic [LinkW-1:0]     head_q, tail_q, cur_q;
	logic [CountW-1:0]    cnt_q;
	logic [LinkW-1:0]     walk_q, newslot_q, tgt_q;
	logic [PosW-1:0]      steps_q;
	logic                 fwd_q;
	logic [DataWidth-1:0] nd_q;
	logic [LinkW-1:0]     np_q, nn_q;
	logic [LinkW-1:0]     pred_q, succ_q, pval_q, sval_q;
	logic                 pend_p_q, pend_s_q;
	logic [SlotW:0]       scan_q;
	logic                 ok_q;
	logic [DataWidth-1:0] dat_q;

	logic                 we;
	logic [SlotW-1:0]     addr;
	logic [NodeW-1:0]     wnode, rnode;
	logic [DataWidth-1:0] rd_data;
	logic [LinkW-1:0]     rd_prev, rd_next;
	logic [LinkW-1:0]     scan_slot;
	logic [CountW-1:0]    half;

	assign {rd_data, rd_prev, rd_next} = rnode;
	assign scan_slot = LinkW'(scan_q);
	assign half = cnt_q >> 1;

	pll_ram #(.Width(NodeW), .Depth(Capacity)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wnode), .rdata(rnode)
	);

	always_comb begin
		we    = 1'b0;
		addr  = walk_q[SlotW-1:0];
		wnode = {nd_q, np_q, nn_q};
		if (state_q == ST_UPD || state_q == ST_UPD2) begin
			we   = 1'b1;
			addr = tgt_q[SlotW-1:0];
		end
	end

	assign busy       = state_q != ST_IDLE;
	assign done       = state_q == ST_DONE;
	assign r_ok       = ok_q;
	assign r_data     = ok_q ? dat_q : '0;
	assign r_count    = cnt_q;
	assign r_has_next = cur_q != NilSlot;

	// For an add, insert or set the node is written in ST_UPD; each neighbour is patched by a
	// read in ST_RD and ST_RDW and a write in ST_UPD2, the predecessor first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= '0;
			pos_q     <= '0;
			val_q     <= '0;
			used_q    <= '0;
			head_q    <= NilSlot;
			tail_q    <= NilSlot;
			cur_q     <= NilSlot;
			cnt_q     <= '0;
			walk_q    <= '0;
			newslot_q <= '0;
			tgt_q     <= '0;
			steps_q   <= '0;
			fwd_q     <= 1'b0;
			nd_q      <= '0;
			np_q      <= '0;
			nn_q      <= '0;
			pred_q    <= '0;
			succ_q    <= '0;
			pval_q    <= '0;
			sval_q    <= '0;
			pend_p_q  <= 1'b0;
			pend_s_q  <= 1'b0;
			scan_q    <= '0;
			ok_q      <= 1'b0;
			dat_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						mode_q   <= mode;
						pos_q    <= position;
						val_q    <= value;
						ok_q     <= 1'b0;
						dat_q    <= '0;
						scan_q   <= '0;
						pend_p_q <= 1'b0;
						pend_s_q <= 1'b0;
						case (mode)
							OP_ADDFIRST, OP_ADDLAST: state_q <= ST_FREE;
							OP_INSERT: state_q <= (position > cnt_q) ? ST_DONE : ST_FREE;
							OP_SET, OP_GET, OP_REMOVE: begin
								if (position >= cnt_q) begin
									state_q <= ST_DONE;
								end else begin
									fwd_q   <= position <= half;
									walk_q  <= (position <= half) ? head_q : tail_q;
									steps_q <= (position <= half) ? position
										: cnt_q - 1'b1 - position;
									state_q <= ST_WALK;
								end
							end
							OP_REMFIRST, OP_REMLAST: begin
								if (cnt_q == '0) begin
									state_q <= ST_DONE;
								end else begin
									walk_q  <= (mode == OP_REMFIRST) ? head_q : tail_q;
									steps_q <= '0;
									state_q <= ST_WALK;
								end
							end
							OP_NEXT: begin
								if (cur_q == NilSlot) begin
									cur_q   <= head_q;
									state_q <= ST_DONE;
								end else begin
									walk_q  <= cur_q;
									steps_q <= '0;
									state_q <= ST_WALK;
								end
							end
							OP_REWIND: begin
								cur_q   <= head_q;
								ok_q    <= 1'b1;
								state_q <= ST_DONE;
							end
							OP_CLEAR: begin
								used_q  <= '0;
								head_q  <= NilSlot;
								tail_q  <= NilSlot;
								cur_q   <= NilSlot;
								cnt_q   <= '0;
								ok_q    <= 1'b1;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_FREE: begin
					if (scan_q == (SlotW+1)'(Capacity)) begin
						state_q <= ST_DONE;
					end else if (!used_q[scan_q[SlotW-1:0]]) begin
						newslot_q <= scan_slot;
						tgt_q     <= scan_slot;
						nd_q      <= val_q;
						pval_q    <= scan_slot;
						sval_q    <= scan_slot;
						if (mode_q == OP_ADDFIRST) begin
							np_q     <= NilSlot;
							nn_q     <= head_q;
							succ_q   <= head_q;
							pend_s_q <= head_q != NilSlot;
							head_q   <= scan_slot;
							if (tail_q == NilSlot) tail_q <= scan_slot;
							used_q[scan_q[SlotW-1:0]] <= 1'b1;
							cnt_q    <= cnt_q + 1'b1;
							ok_q     <= 1'b1;
							state_q  <= ST_UPD;
						end else if (mode_q == OP_ADDLAST || pos_q == cnt_q) begin
							np_q     <= tail_q;
							nn_q     <= NilSlot;
							pred_q   <= tail_q;
							pend_p_q <= tail_q != NilSlot;
							tail_q   <= scan_slot;
							if (head_q == NilSlot) head_q <= scan_slot;
							used_q[scan_q[SlotW-1:0]] <= 1'b1;
							cnt_q    <= cnt_q + 1'b1;
							ok_q     <= 1'b1;
							state_q  <= ST_UPD;
						end else begin
							fwd_q   <= pos_q <= half;
							walk_q  <= (pos_q <= half) ? head_q : tail_q;
							steps_q <= (pos_q <= half) ? pos_q : cnt_q - 1'b1 - pos_q;
							state_q <= ST_WALK;
						end
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_WALK: state_q <= ST_WREAD;
				ST_WREAD: begin
					if (steps_q != '0) begin
						walk_q  <= fwd_q ? rd_next : rd_prev;
						steps_q <= steps_q - 1'b1;
						state_q <= ST_WALK;
					end else begin
						case (mode_q)
							OP_INSERT: begin
								np_q     <= rd_prev;
								nn_q     <= walk_q;
								pred_q   <= rd_prev;
								succ_q   <= walk_q;
								pend_p_q <= rd_prev != NilSlot;
								pend_s_q <= 1'b1;
								if (rd_prev == NilSlot) head_q <= newslot_q;
								used_q[newslot_q[SlotW-1:0]] <= 1'b1;
								cnt_q    <= cnt_q + 1'b1;
								ok_q     <= 1'b1;
								state_q  <= ST_UPD;
							end
							OP_SET: begin
								dat_q   <= rd_data;
								ok_q    <= 1'b1;
								nd_q    <= val_q;
								np_q    <= rd_prev;
								nn_q    <= rd_next;
								tgt_q   <= walk_q;
								state_q <= ST_UPD;
							end
							OP_GET: begin
								dat_q   <= rd_data;
								ok_q    <= 1'b1;
								state_q <= ST_DONE;
							end
							OP_NEXT: begin
								dat_q   <= rd_data;
								ok_q    <= 1'b1;
								cur_q   <= rd_next;
								state_q <= ST_DONE;
							end
							default: begin
								dat_q    <= rd_data;
								ok_q     <= 1'b1;
								used_q[walk_q[SlotW-1:0]] <= 1'b0;
								cnt_q    <= cnt_q - 1'b1;
								pred_q   <= rd_prev;
								succ_q   <= rd_next;
								pval_q   <= rd_next;
								sval_q   <= rd_prev;
								pend_p_q <= rd_prev != NilSlot;
								pend_s_q <= rd_next != NilSlot;
								if (rd_prev == NilSlot) head_q <= rd_next;
								if (rd_next == NilSlot) tail_q <= rd_prev;
								if (rd_prev != NilSlot) begin
									walk_q  <= rd_prev;
									state_q <= ST_RD;
								end else if (rd_next != NilSlot) begin
									walk_q  <= rd_next;
									state_q <= ST_RD;
								end else begin
									state_q <= ST_DONE;
								end
							end
						endcase
					end
				end
				ST_UPD: begin
					if (pend_p_q) begin
						walk_q  <= pred_q;
						state_q <= ST_RD;
					end else if (pend_s_q) begin
						walk_q  <= succ_q;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_RD: state_q <= ST_RDW;
				ST_RDW: begin
					tgt_q <= walk_q;
					nd_q  <= rd_data;
					if (pend_p_q) begin
						np_q     <= rd_prev;
						nn_q     <= pval_q;
						pend_p_q <= 1'b0;
					end else begin
						np_q     <= sval_q;
						nn_q     <= rd_next;
						pend_s_q <= 1'b0;
					end
					state_q <= ST_UPD2;
				end
				ST_UPD2: begin
					if (pend_s_q) begin
						walk_q  <= succ_q;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: hdl/pll_checker.sv
// Port-level checker for the positional linked list engine, bound to the top level.
// Depends on pll_pkg and pll_if.
module pll_checker import pll_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [CountW-1:0] count
);
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count <= CountW'(Capacity)) else $error("count beyond capacity");
	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready) else $error("item taken while result held");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("second item taken while busy");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind positional_linked_list_engine pll_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .count(out_ch.payload.count)
);
